[rtl/core/tsa_pkg.sv]
// shared types and constants for the image transform source address block
// no dependencies; imported by every module of the block
package tsa_pkg;

  // largest source or output dimension in pixels
  localparam int unsigned MaxDim = 4096;

  // field widths
  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned IndexW = 24;
  localparam int unsigned NumDivCells = CoordW;

  // transform mode codes
  typedef enum logic [2:0] {
    ModeFlipH = 3'd0,
    ModeFlipV = 3'd1,
    ModeRotR  = 3'd2,
    ModeRotL  = 3'd3,
    ModeScale = 3'd4,
    ModeCrop  = 3'd5
  } tsa_mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgMode      = 3'd0,
    CfgSrcWidth  = 3'd1,
    CfgSrcHeight = 3'd2,
    CfgOutWidth  = 3'd3,
    CfgOutHeight = 3'd4,
    CfgCropX     = 3'd5,
    CfgCropY     = 3'd6
  } tsa_cfg_idx_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [DimW-1:0]   src_width;
    logic [DimW-1:0]   src_height;
    logic [DimW-1:0]   out_width;
    logic [DimW-1:0]   out_height;
    logic [CoordW-1:0] crop_x;
    logic [CoordW-1:0] crop_y;
  } tsa_cfg_t;

  // one request in flight through the cell chain
  typedef struct packed {
    logic              is_scale;
    logic              out_of_range;
    logic              config_error;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [IndexW-1:0] rem_x;
    logic [IndexW-1:0] rem_y;
  } tsa_item_t;

endpackage

[rtl/core/tsa_front.sv]
// front stage: config checks, frame check, direct mappings and scale dividends
// depends on tsa_pkg
module tsa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tsa_pkg::tsa_cfg_t        cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [tsa_pkg::CoordW-1:0] dst_x_i,
  input  logic [tsa_pkg::CoordW-1:0] dst_y_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output tsa_pkg::tsa_item_t       out_item_o
);
  import tsa_pkg::*;

  localparam logic [DimW-1:0] MaxDimV = DimW'(MaxDim);

  logic              valid_q, valid_d;
  tsa_item_t         item_q, item_d;
  logic              accept;
  logic              err_src, err_out, err_crop, err_mode, err;
  logic              is_rot, is_sized;
  logic [DimW-1:0]   fw, fh;
  logic              oor;
  logic [DimW-1:0]   w, h;
  logic [DimW+CoordW-1:0] prod_x, prod_y;
  logic [CoordW-1:0] map_x, map_y;

  assign w = cfg_i.src_width;
  assign h = cfg_i.src_height;

  // handshake: free or draining stage takes a new request
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // configuration checks
  assign is_rot   = (cfg_i.mode == ModeRotR) || (cfg_i.mode == ModeRotL);
  assign is_sized = (cfg_i.mode == ModeScale) || (cfg_i.mode == ModeCrop);
  assign err_src  = (w == '0) || (h == '0) || (w > MaxDimV) || (h > MaxDimV);
  assign err_mode = cfg_i.mode > ModeCrop;
  assign err_out  = is_sized && ((cfg_i.out_width == '0) || (cfg_i.out_height == '0) ||
                    (cfg_i.out_width > MaxDimV) || (cfg_i.out_height > MaxDimV));
  assign err_crop = (cfg_i.mode == ModeCrop) &&
                    (((DimW+1)'(cfg_i.crop_x) + (DimW+1)'(cfg_i.out_width) > (DimW+1)'(w)) ||
                     ((DimW+1)'(cfg_i.crop_y) + (DimW+1)'(cfg_i.out_height) > (DimW+1)'(h)));
  assign err = err_src || err_mode || err_out || err_crop;

  // output frame size
  always_comb begin
    if (is_rot) begin
      fw = h;
      fh = w;
    end else if (is_sized) begin
      fw = cfg_i.out_width;
      fh = cfg_i.out_height;
    end else begin
      fw = w;
      fh = h;
    end
  end
  assign oor = (DimW'(dst_x_i) >= fw) || (DimW'(dst_y_i) >= fh);

  // scale dividends
  assign prod_x = (DimW+CoordW)'(dst_x_i) * (DimW+CoordW)'(w);
  assign prod_y = (DimW+CoordW)'(dst_y_i) * (DimW+CoordW)'(h);

  // direct coordinate mappings
  always_comb begin
    case (cfg_i.mode)
      ModeFlipH: begin
        map_x = CoordW'(w - DimW'(1) - DimW'(dst_x_i));
        map_y = dst_y_i;
      end
      ModeFlipV: begin
        map_x = dst_x_i;
        map_y = CoordW'(h - DimW'(1) - DimW'(dst_y_i));
      end
      ModeRotR: begin
        map_x = CoordW'(w - DimW'(1) - DimW'(dst_y_i));
        map_y = dst_x_i;
      end
      ModeRotL: begin
        map_x = dst_y_i;
        map_y = CoordW'(h - DimW'(1) - DimW'(dst_x_i));
      end
      ModeScale: begin
        map_x = '0;
        map_y = '0;
      end
      default: begin
        map_x = dst_x_i + cfg_i.crop_x;
        map_y = dst_y_i + cfg_i.crop_y;
      end
    endcase
  end

  // next item
  always_comb begin
    item_d              = item_q;
    item_d.config_error = err;
    item_d.out_of_range = !err && oor;
    item_d.is_scale     = !err && !oor && (cfg_i.mode == ModeScale);
    item_d.rem_x        = prod_x[IndexW-1:0];
    item_d.rem_y        = prod_y[IndexW-1:0];
    if (err || oor) begin
      item_d.sx = '0;
      item_d.sy = '0;
    end else begin
      item_d.sx = map_x;
      item_d.sy = map_y;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[rtl/core/tsa_div_cell.sv]
// one restoring division cell: settles one quotient bit of both scale axes
// depends on tsa_pkg
module tsa_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsa_pkg::tsa_cfg_t  cfg_i,
  input  logic [3:0]         bit_pos_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsa_pkg::tsa_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsa_pkg::tsa_item_t out_item_o
);
  import tsa_pkg::*;

  localparam int unsigned CmpW = IndexW + 1;

  logic            valid_q, valid_d;
  tsa_item_t       item_q, item_d;
  logic            accept;
  logic [CmpW-1:0] div_x, div_y;
  logic            ge_x, ge_y;
  logic [CoordW-1:0] qbit;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // divisor aligned to this cell's quotient bit
  assign div_x = CmpW'(cfg_i.out_width) << bit_pos_i;
  assign div_y = CmpW'(cfg_i.out_height) << bit_pos_i;
  assign ge_x  = CmpW'(in_item_i.rem_x) >= div_x;
  assign ge_y  = CmpW'(in_item_i.rem_y) >= div_y;
  assign qbit  = CoordW'(1) << bit_pos_i;

  // trial subtract, only for scale requests
  always_comb begin
    item_d = in_item_i;
    if (in_item_i.is_scale) begin
      if (ge_x) begin
        item_d.rem_x = in_item_i.rem_x - div_x[IndexW-1:0];
        item_d.sx    = in_item_i.sx | qbit;
      end
      if (ge_y) begin
        item_d.rem_y = in_item_i.rem_y - div_y[IndexW-1:0];
        item_d.sy    = in_item_i.sy | qbit;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[rtl/core/tsa_index.sv]
// output stage: linear source index and the result register
// depends on tsa_pkg
module tsa_index (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tsa_pkg::tsa_cfg_t          cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tsa_pkg::tsa_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tsa_pkg::CoordW-1:0] src_x_o,
  output logic [tsa_pkg::CoordW-1:0] src_y_o,
  output logic [tsa_pkg::IndexW-1:0] src_index_o,
  output logic                       out_of_range_o,
  output logic                       config_error_o
);
  import tsa_pkg::*;

  localparam int unsigned ProdW = CoordW + DimW;

  logic              valid_q, valid_d;
  logic              accept;
  logic [ProdW-1:0]  row_base;
  logic [IndexW-1:0] index_d, index_q;
  logic [CoordW-1:0] sx_q, sy_q;
  logic              oor_q, err_q;

  assign in_ready_o = !valid_q || !out_stall_i;
  assign accept     = in_valid_i && in_ready_o;

  // row start plus column
  assign row_base = ProdW'(in_item_i.sy) * ProdW'(cfg_i.src_width);
  assign index_d  = row_base[IndexW-1:0] + IndexW'(in_item_i.sx);

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q    <= in_item_i.sx;
      sy_q    <= in_item_i.sy;
      index_q <= index_d;
      oor_q   <= in_item_i.out_of_range;
      err_q   <= in_item_i.config_error;
    end
  end

  assign out_valid_o    = valid_q;
  assign src_x_o        = sx_q;
  assign src_y_o        = sy_q;
  assign src_index_o    = index_q;
  assign out_of_range_o = oor_q;
  assign config_error_o = err_q;

endmodule

[rtl/core/image_transform_source_address.sv]
// top level: config registers, front stage, divider cell chain, index stage
// depends on tsa_pkg, tsa_front, tsa_div_cell, tsa_index
//
// Takes one destination pixel per clock unless stalled and returns the source
// pixel to copy for the selected flip, rotate, scale or crop, plus its linear
// index over unpadded rows and the out-of-range and config-error flags.
// Throughput is one request per cycle while not stalled. The pipeline is one
// front stage (checks, mappings and the scale dividend multiply), a chain of
// 12 divider cells that each settle one quotient bit of the nearest-neighbor
// scale, and one stage for the row multiply-add that also holds the result.
// Every stage has its own valid flag, so bubbles close up under output stall.
// Config is written through cfg_valid_i/cfg_index_i/cfg_data_i, always
// ready, and must only change while no request is in flight.
module image_transform_source_address (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [2:0]                 cfg_index_i,
  input  logic [tsa_pkg::DimW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tsa_pkg::CoordW-1:0] dst_x_i,
  input  logic [tsa_pkg::CoordW-1:0] dst_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tsa_pkg::CoordW-1:0] src_x_o,
  output logic [tsa_pkg::CoordW-1:0] src_y_o,
  output logic [tsa_pkg::IndexW-1:0] src_index_o,
  output logic                       out_of_range_o,
  output logic                       config_error_o
);
  import tsa_pkg::*;

  tsa_cfg_t  cfg_q, cfg_d;
  logic      front_ready;
  logic      chain_valid [NumDivCells+1];
  logic      chain_ready [NumDivCells+1];
  tsa_item_t chain_item  [NumDivCells+1];

  // config write port
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (tsa_cfg_idx_e'(cfg_index_i))
        CfgMode:      cfg_d.mode       = cfg_data_i[2:0];
        CfgSrcWidth:  cfg_d.src_width  = cfg_data_i;
        CfgSrcHeight: cfg_d.src_height = cfg_data_i;
        CfgOutWidth:  cfg_d.out_width  = cfg_data_i;
        CfgOutHeight: cfg_d.out_height = cfg_data_i;
        CfgCropX:     cfg_d.crop_x     = cfg_data_i[CoordW-1:0];
        CfgCropY:     cfg_d.crop_y     = cfg_data_i[CoordW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= ModeFlipH;
      cfg_q.src_width  <= DimW'(640);
      cfg_q.src_height <= DimW'(480);
      cfg_q.out_width  <= DimW'(640);
      cfg_q.out_height <= DimW'(480);
      cfg_q.crop_x     <= '0;
      cfg_q.crop_y     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front stage
  tsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .dst_x_i     (dst_x_i),
    .dst_y_i     (dst_y_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_item_o  (chain_item[0])
  );

  assign in_stall_o = !front_ready;

  // divider cell chain, most significant quotient bit first
  for (genvar g = 0; g < NumDivCells; g++) begin : g_cell
    tsa_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg_q),
      .bit_pos_i   (4'(NumDivCells - 1 - g)),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_item_i   (chain_item[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_item_o  (chain_item[g+1])
    );
  end

  // index and result stage
  tsa_index u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (chain_valid[NumDivCells]),
    .in_ready_o     (chain_ready[NumDivCells]),
    .in_item_i      (chain_item[NumDivCells]),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .src_x_o        (src_x_o),
    .src_y_o        (src_y_o),
    .src_index_o    (src_index_o),
    .out_of_range_o (out_of_range_o),
    .config_error_o (config_error_o)
  );

endmodule

[rtl/core/tsa_checker.sv]
// port-level checks for the image transform source address block
// depends on tsa_pkg; bound to image_transform_source_address
module tsa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [tsa_pkg::CoordW-1:0] src_x_o,
  input logic [tsa_pkg::CoordW-1:0] src_y_o,
  input logic [tsa_pkg::IndexW-1:0] src_index_o,
  input logic                       out_of_range_o,
  input logic                       config_error_o
);
  import tsa_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(src_index_o) && $stable(src_x_o))
    else $error("stalled result changed");

  // an empty result register means the whole chain can take a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a config error gives a zero address and no range flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && config_error_o |->
      !out_of_range_o && src_x_o == '0 && src_y_o == '0 && src_index_o == '0)
    else $error("config error result not cleared");

  // an out-of-frame request gives a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      src_x_o == '0 && src_y_o == '0 && src_index_o == '0)
    else $error("out of range result not cleared");

endmodule

bind image_transform_source_address tsa_checker u_tsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .src_x_o        (src_x_o),
  .src_y_o        (src_y_o),
  .src_index_o    (src_index_o),
  .out_of_range_o (out_of_range_o),
  .config_error_o (config_error_o)
);

[tb/sv/source_address_checker.sv]
// checker for image_transform_source_address: tracks config writes, predicts each
// source address and compares every accepted result against the oldest prediction
// depends on tsa_pkg; instantiated beside the block by image_transform_source_address_tb
module source_address_checker
  import tsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [DimW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [CoordW-1:0] dst_x_i,
  input  logic [CoordW-1:0] dst_y_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [CoordW-1:0] src_x_i,
  input  logic [CoordW-1:0] src_y_i,
  input  logic [IndexW-1:0] src_index_i,
  input  logic              out_of_range_i,
  input  logic              config_error_i,
  output int                pending_o,
  output int                fail_count_o,
  output int                checked_o,
  output int                outside_o,
  output int                cfg_errors_o
);

  typedef struct packed {
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [IndexW-1:0] idx;
    logic              oor;
    logic              cerr;
  } src_addr_t;

  localparam tsa_cfg_t ResetCfg = '{
    mode:       ModeFlipH,
    src_width:  13'd640,
    src_height: 13'd480,
    out_width:  13'd640,
    out_height: 13'd480,
    crop_x:     12'd0,
    crop_y:     12'd0
  };

  tsa_cfg_t  cfg;
  src_addr_t expected_addr_q[$];
  int        fails;
  int        checked;
  int        outside;
  int        cfg_errors;

  assign fail_count_o = fails;
  assign checked_o    = checked;
  assign outside_o    = outside;
  assign cfg_errors_o = cfg_errors;

  initial begin
    fails      = 0;
    checked    = 0;
    outside    = 0;
    cfg_errors = 0;
    cfg        = ResetCfg;
  end

  // source pixel for one destination pixel under the given configuration
  function automatic src_addr_t predict_source(tsa_cfg_t c, logic [CoordW-1:0] dx,
                                               logic [CoordW-1:0] dy);
    src_addr_t   res;
    int unsigned w, h, ow, oh, cx, cy, fw, fh, sx, sy, idx;
    logic        bad;
    res = '0;
    w   = c.src_width;
    h   = c.src_height;
    ow  = c.out_width;
    oh  = c.out_height;
    cx  = c.crop_x;
    cy  = c.crop_y;
    bad = (w == 0) || (h == 0) || (w > MaxDim) || (h > MaxDim) || (c.mode > ModeCrop);
    if (c.mode == ModeScale || c.mode == ModeCrop)
      bad = bad || (ow == 0) || (oh == 0) || (ow > MaxDim) || (oh > MaxDim);
    if (c.mode == ModeCrop)
      bad = bad || (cx + ow > w) || (cy + oh > h);
    if (bad) begin
      res.cerr = 1'b1;
      return res;
    end
    // output frame size depends on the transform
    if (c.mode == ModeRotR || c.mode == ModeRotL) begin
      fw = h;
      fh = w;
    end else if (c.mode == ModeScale || c.mode == ModeCrop) begin
      fw = ow;
      fh = oh;
    end else begin
      fw = w;
      fh = h;
    end
    if (dx >= fw || dy >= fh) begin
      res.oor = 1'b1;
      return res;
    end
    case (c.mode)
      ModeFlipH: begin
        sx = w - 1 - dx;
        sy = dy;
      end
      ModeFlipV: begin
        sx = dx;
        sy = h - 1 - dy;
      end
      ModeRotR: begin
        sx = w - 1 - dy;
        sy = dx;
      end
      ModeRotL: begin
        sx = dy;
        sy = h - 1 - dx;
      end
      ModeScale: begin
        sx = (dx * w) / ow;
        sy = (dy * h) / oh;
      end
      default: begin
        sx = dx + cx;
        sy = dy + cy;
      end
    endcase
    idx     = sy * w + sx;
    res.sx  = sx[CoordW-1:0];
    res.sy  = sy[CoordW-1:0];
    res.idx = idx[IndexW-1:0];
    return res;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // follow config writes, queue a prediction per request, check each result
  always @(posedge clk_i or negedge rst_ni) begin : watch
    src_addr_t got;
    src_addr_t want;
    if (!rst_ni) begin
      cfg = ResetCfg;
      expected_addr_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgMode:      cfg.mode = cfg_data_i[2:0];
          CfgSrcWidth:  cfg.src_width = cfg_data_i;
          CfgSrcHeight: cfg.src_height = cfg_data_i;
          CfgOutWidth:  cfg.out_width = cfg_data_i;
          CfgOutHeight: cfg.out_height = cfg_data_i;
          CfgCropX:     cfg.crop_x = cfg_data_i[CoordW-1:0];
          CfgCropY:     cfg.crop_y = cfg_data_i[CoordW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_addr_q.push_back(predict_source(cfg, dst_x_i, dst_y_i));
      if (out_valid_i && !out_stall_i) begin
        got.sx   = src_x_i;
        got.sy   = src_y_i;
        got.idx  = src_index_i;
        got.oor  = out_of_range_i;
        got.cerr = config_error_i;
        if (expected_addr_q.size() == 0) begin
          $error("result with no request outstanding: src_x %0d src_y %0d", got.sx, got.sy);
          fails++;
        end else begin
          want = expected_addr_q.pop_front();
          compare_field("src_x", want.sx, got.sx);
          compare_field("src_y", want.sy, got.sy);
          compare_field("src_index", want.idx, got.idx);
          compare_field("out_of_range", want.oor, got.oor);
          compare_field("config_error", want.cerr, got.cerr);
          checked++;
          if (want.oor) outside++;
          if (want.cerr) cfg_errors++;
        end
      end
      pending_o <= expected_addr_q.size();
    end
  end

endmodule

[tb/sv/image_transform_source_address_tb.sv]
// testbench top for image_transform_source_address: clock, reset, config writes,
// directed and random destination pixels with random sender gaps and output stalls
// depends on tsa_pkg, image_transform_source_address and source_address_checker
module image_transform_source_address_tb;
  import tsa_pkg::*;

  localparam logic [2:0] ModeUnused = 3'd7;
  localparam int unsigned ItemTarget = 1250;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [DimW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CoordW-1:0] dst_x_i = '0;
  logic [CoordW-1:0] dst_y_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CoordW-1:0] src_x_o;
  logic [CoordW-1:0] src_y_o;
  logic [IndexW-1:0] src_index_o;
  logic              out_of_range_o;
  logic              config_error_o;

  int pending;
  int fail_count;
  int checked;
  int outside;
  int cfg_errors;

  int unsigned items_sent = 0;
  int unsigned cfg_sets = 0;
  int unsigned send_idle_pct = 24;
  int unsigned recv_stall_pct = 63;

  image_transform_source_address uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dst_x_i        (dst_x_i),
    .dst_y_i        (dst_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .src_x_o        (src_x_o),
    .src_y_o        (src_y_o),
    .src_index_o    (src_index_o),
    .out_of_range_o (out_of_range_o),
    .config_error_o (config_error_o)
  );

  source_address_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .dst_x_i        (dst_x_i),
    .dst_y_i        (dst_y_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .src_x_i        (src_x_o),
    .src_y_i        (src_y_o),
    .src_index_i    (src_index_o),
    .out_of_range_i (out_of_range_o),
    .config_error_i (config_error_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .checked_o      (checked),
    .outside_o      (outside),
    .cfg_errors_o   (cfg_errors)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // random output stall
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // run limit
  initial begin
    #2000000;
    $display("image_transform_source_address regression: fail");
    $finish;
  end

  function automatic tsa_cfg_t make_cfg(logic [2:0] mode, int unsigned w, int unsigned h,
                                        int unsigned ow, int unsigned oh,
                                        int unsigned cx, int unsigned cy);
    tsa_cfg_t c;
    c.mode       = mode;
    c.src_width  = DimW'(w);
    c.src_height = DimW'(h);
    c.out_width  = DimW'(ow);
    c.out_height = DimW'(oh);
    c.crop_x     = CoordW'(cx);
    c.crop_y     = CoordW'(cy);
    return c;
  endfunction

  // mostly small or legal sizes, now and then zero or oversize
  function automatic logic [DimW-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return DimW'($urandom_range(64, 1));
    if (r < 80) return DimW'($urandom_range(MaxDim, 1));
    if (r < 88) return DimW'(MaxDim);
    if (r < 97) return DimW'($urandom_range(3, 1));
    if (r < 98) return '0;
    return DimW'($urandom_range(8191, MaxDim + 1));
  endfunction

  // one request; the idle and stall mix follows progress through the run
  task automatic push_request(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    if (items_sent < 420) begin
      send_idle_pct  = 24;
      recv_stall_pct = 63;
    end else if (items_sent < 840) begin
      send_idle_pct  = 63;
      recv_stall_pct = 24;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    dst_x_i    <= x;
    dst_y_i    <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_reg(input tsa_cfg_idx_e idx, input logic [DimW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // drain the pipeline, then rewrite every register
  task automatic set_config(input tsa_cfg_t c);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    write_reg(CfgMode, DimW'(c.mode));
    write_reg(CfgSrcWidth, c.src_width);
    write_reg(CfgSrcHeight, c.src_height);
    write_reg(CfgOutWidth, c.out_width);
    write_reg(CfgOutHeight, c.out_height);
    write_reg(CfgCropX, DimW'(c.crop_x));
    write_reg(CfgCropY, DimW'(c.crop_y));
    cfg_valid_i <= 1'b0;
    cfg_sets++;
  endtask

  // random configuration followed by a burst of pixels, mostly inside the frame
  task automatic run_random_phase(input int unsigned count);
    tsa_cfg_t          c;
    int unsigned       fw;
    int unsigned       fh;
    int unsigned       kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    c.mode = ($urandom_range(99) < 92) ? 3'($urandom_range(5, 0)) : 3'($urandom_range(7, 6));
    c.src_width  = pick_dim();
    c.src_height = pick_dim();
    c.out_width  = pick_dim();
    c.out_height = pick_dim();
    c.crop_x     = CoordW'($urandom);
    c.crop_y     = CoordW'($urandom);
    // crop mostly gets a window that fits, sometimes one pixel too wide or tall
    if (c.mode == ModeCrop && c.src_width != 0 && c.src_width <= MaxDim &&
        c.src_height != 0 && c.src_height <= MaxDim && $urandom_range(9) != 0) begin
      c.crop_x     = CoordW'($urandom_range(c.src_width - 1, 0));
      c.crop_y     = CoordW'($urandom_range(c.src_height - 1, 0));
      c.out_width  = DimW'($urandom_range(c.src_width - c.crop_x, 1));
      c.out_height = DimW'($urandom_range(c.src_height - c.crop_y, 1));
      if ($urandom_range(9) == 0) c.out_width = c.out_width + 1'b1;
      if ($urandom_range(9) == 0) c.out_height = c.out_height + 1'b1;
    end
    set_config(c);
    case (c.mode)
      ModeRotR, ModeRotL: begin
        fw = c.src_height;
        fh = c.src_width;
      end
      ModeScale, ModeCrop: begin
        fw = c.out_width;
        fh = c.out_height;
      end
      default: begin
        fw = c.src_width;
        fh = c.src_height;
      end
    endcase
    if (fw == 0 || fw > MaxDim) fw = MaxDim;
    if (fh == 0 || fh > MaxDim) fh = MaxDim;
    repeat (count) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        x = CoordW'($urandom_range(fw - 1, 0));
        y = CoordW'($urandom_range(fh - 1, 0));
      end else if (kind < 90) begin
        x = CoordW'(fw - 1 + $urandom_range(2, 0));
        y = CoordW'(fh - 1 + $urandom_range(2, 0));
      end else begin
        x = CoordW'($urandom);
        y = CoordW'($urandom);
      end
      push_request(x, y);
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: 640x480 horizontal flip
    push_request(12'd0, 12'd0);
    push_request(12'd639, 12'd479);
    push_request(12'd640, 12'd0);
    push_request(12'd4095, 12'd4095);
    // largest frame, largest index
    set_config(make_cfg(ModeFlipV, 4096, 4096, 1, 1, 0, 0));
    push_request(12'd4095, 12'd0);
    push_request(12'd0, 12'd4095);
    // rotations on a one-pixel wide and a three-pixel tall source
    set_config(make_cfg(ModeRotR, 1, 4096, 0, 0, 0, 0));
    push_request(12'd4095, 12'd0);
    push_request(12'd0, 12'd1);
    set_config(make_cfg(ModeRotL, 4096, 3, 0, 0, 4095, 4095));
    push_request(12'd2, 12'd4095);
    push_request(12'd3, 12'd0);
    // scale down to one column, stretch rows
    set_config(make_cfg(ModeScale, 4096, 3, 1, 4096, 0, 0));
    push_request(12'd0, 12'd4095);
    push_request(12'd1, 12'd0);
    // crop of the last pixel
    set_config(make_cfg(ModeCrop, 4096, 4096, 1, 1, 4095, 4095));
    push_request(12'd0, 12'd0);
    push_request(12'd0, 12'd1);
    // crop window one past the right edge
    set_config(make_cfg(ModeCrop, 4096, 4096, 4096, 1, 1, 0));
    push_request(12'd0, 12'd0);
    // zero output width in scale
    set_config(make_cfg(ModeScale, 64, 64, 0, 8, 0, 0));
    push_request(12'd5, 12'd5);
    // unused mode code
    set_config(make_cfg(ModeUnused, 64, 64, 64, 64, 0, 0));
    push_request(12'd0, 12'd0);
    // zero and oversize source sizes
    set_config(make_cfg(ModeFlipH, 0, 16, 16, 16, 0, 0));
    push_request(12'd0, 12'd0);
    set_config(make_cfg(ModeFlipH, 16, 8191, 8191, 8191, 0, 0));
    push_request(12'd0, 12'd0);
    // single-pixel image
    set_config(make_cfg(ModeFlipH, 1, 1, 1, 1, 0, 0));
    push_request(12'd0, 12'd0);

    while (items_sent < ItemTarget) run_random_phase($urandom_range(70, 30));

    // drain and settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests over %0d configuration sets after reset", items_sent,
             cfg_sets);
    $display("results checked %0d: %0d outside the frame, %0d with a bad configuration",
             checked, outside, cfg_errors);
    if (fail_count == 0) begin
      $display("image_transform_source_address regression: pass");
    end else begin
      $display("image_transform_source_address regression: fail");
    end
    $finish;
  end

endmodule
